>>> rtl/ucpc_pkg.sv
// ----------------------------------------------------------------------------
// UDP unicast packet classifier package
// Shared constants, reason codes and the per-frame status record.
// ----------------------------------------------------------------------------
package ucpc_pkg;

   localparam int NUM_QUEUES_DEFAULT = 64;
   localparam int QUEUE_W            = 6;
   localparam int OFFSET_W           = 7;
   localparam int CNT_W              = 64;
   localparam int NUM_COUNTERS       = 5;

   localparam logic [OFFSET_W-1:0] OFFSET_MAX      = 7'd127;
   localparam logic [OFFSET_W-1:0] OFS_ETYPE_HI    = 7'd12;
   localparam logic [OFFSET_W-1:0] OFS_ETYPE_LO    = 7'd13;
   localparam logic [OFFSET_W-1:0] OFS_VER_IHL     = 7'd14;
   localparam logic [OFFSET_W-1:0] OFS_PROTOCOL    = 7'd23;
   localparam logic [OFFSET_W-1:0] OFS_DST_ADDR_LO = 7'd30;
   localparam logic [OFFSET_W-1:0] OFS_DST_ADDR_HI = 7'd33;

   localparam logic [7:0] ETH_HDR_LEN = 8'd14;
   localparam logic [7:0] IP_MIN_LEN  = 8'd20;
   localparam logic [7:0] UDP_HDR_LEN = 8'd8;
   localparam logic [3:0] IHL_MIN     = 4'd5;

   localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
   localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
   localparam logic [7:0] PROTO_UDP     = 8'd17;

   localparam logic [1:0] CSR_TARGET_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_TARGET_PORT    = 2'd1;
   localparam logic [1:0] CSR_FILTER_ENABLE  = 2'd2;
   localparam logic [1:0] CSR_SOCKET_MASK    = 2'd3;

   localparam logic [3:0] STOP_REDIRECTED = 4'd0;
   localparam logic [3:0] STOP_SHORT_ETH  = 4'd1;
   localparam logic [3:0] STOP_NOT_IPV4   = 4'd2;
   localparam logic [3:0] STOP_SHORT_IP   = 4'd3;
   localparam logic [3:0] STOP_NOT_UDP    = 4'd4;
   localparam logic [3:0] STOP_BAD_IHL    = 4'd5;
   localparam logic [3:0] STOP_SHORT_UDP  = 4'd6;
   localparam logic [3:0] STOP_DISABLED   = 4'd7;
   localparam logic [3:0] STOP_NO_MATCH   = 4'd8;
   localparam logic [3:0] STOP_NO_SOCKET  = 4'd9;

   localparam int CNT_FRAMES     = 0;
   localparam int CNT_IPV4       = 1;
   localparam int CNT_UDP        = 2;
   localparam int CNT_MATCHED    = 3;
   localparam int CNT_REDIRECTED = 4;

   typedef struct packed {
      logic [OFFSET_W-1:0] pos;
      logic [3:0]          header_words;
      logic                ethertype_ok;
      logic                protocol_ok;
      logic                address_match;
      logic                port_match;
      logic [QUEUE_W-1:0]  frame_queue;
   } frame_status_type;

endpackage

>>> rtl/ucpc_frame_parser.sv
// ----------------------------------------------------------------------------
// UDP classifier frame parser
// Tracks byte position and header checks; reports the status after this byte.
// ----------------------------------------------------------------------------
module ucpc_frame_parser
   import ucpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_fire,
   input  logic [7:0]             data_byte,
   input  logic                   end_of_frame,
   input  logic [QUEUE_W-1:0]     rx_queue,
   input  logic [31:0]            target_address,
   input  logic [15:0]            target_udp_port,
   output frame_status_type       status
);

   logic [OFFSET_W-1:0] offset_ff;
   logic [3:0]          hwords_ff;
   logic                eth_ok_ff;
   logic                proto_ok_ff;
   logic                addr_ok_ff;
   logic                port_ok_ff;
   logic [QUEUE_W-1:0]  queue_ff;

   logic [OFFSET_W-1:0] offset_in;
   logic [OFFSET_W-1:0] udp_base;
   logic [1:0]          addr_idx;
   logic [7:0]          addr_byte;
   frame_status_type    nxt;

   assign udp_base = OFFSET_W'(ETH_HDR_LEN) + OFFSET_W'({hwords_ff, 2'b00});
   assign addr_idx = offset_ff[1:0] - 2'd2;

   always_comb begin
      unique case (addr_idx)
         2'd0:    addr_byte = target_address[31:24];
         2'd1:    addr_byte = target_address[23:16];
         2'd2:    addr_byte = target_address[15:8];
         default: addr_byte = target_address[7:0];
      endcase
   end

   always_comb begin
      nxt.pos           = offset_ff;
      nxt.header_words  = hwords_ff;
      nxt.ethertype_ok  = eth_ok_ff;
      nxt.protocol_ok   = proto_ok_ff;
      nxt.address_match = addr_ok_ff;
      nxt.port_match    = port_ok_ff;
      nxt.frame_queue   = (offset_ff == '0) ? rx_queue : queue_ff;

      if (offset_ff == OFS_ETYPE_HI) begin
         nxt.ethertype_ok = (data_byte == ETYPE_IPV4_HI);
      end else if (offset_ff == OFS_ETYPE_LO) begin
         nxt.ethertype_ok = eth_ok_ff && (data_byte == ETYPE_IPV4_LO);
      end else if (offset_ff == OFS_VER_IHL) begin
         nxt.header_words = data_byte[3:0];
      end else if (offset_ff == OFS_PROTOCOL) begin
         nxt.protocol_ok = (data_byte == PROTO_UDP);
      end else if (offset_ff >= OFS_DST_ADDR_LO && offset_ff <= OFS_DST_ADDR_HI) begin
         nxt.address_match = (data_byte == addr_byte) &&
                             ((offset_ff == OFS_DST_ADDR_LO) || addr_ok_ff);
      end

      if (offset_ff > OFS_VER_IHL) begin
         if (offset_ff == udp_base + OFFSET_W'(2)) begin
            nxt.port_match = (data_byte == target_udp_port[15:8]);
         end else if (offset_ff == udp_base + OFFSET_W'(3)) begin
            nxt.port_match = port_ok_ff && (data_byte == target_udp_port[7:0]);
         end
      end
   end

   assign offset_in = (offset_ff == OFFSET_MAX) ? offset_ff : offset_ff + OFFSET_W'(1);
   assign status    = nxt;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         hwords_ff   <= '0;
         eth_ok_ff   <= 1'b0;
         proto_ok_ff <= 1'b0;
         addr_ok_ff  <= 1'b0;
         port_ok_ff  <= 1'b0;
         queue_ff    <= '0;
      end else if (byte_fire) begin
         if (end_of_frame) begin
            offset_ff   <= '0;
            hwords_ff   <= '0;
            eth_ok_ff   <= 1'b0;
            proto_ok_ff <= 1'b0;
            addr_ok_ff  <= 1'b0;
            port_ok_ff  <= 1'b0;
            queue_ff    <= '0;
         end else begin
            offset_ff   <= offset_in;
            hwords_ff   <= nxt.header_words;
            eth_ok_ff   <= nxt.ethertype_ok;
            proto_ok_ff <= nxt.protocol_ok;
            addr_ok_ff  <= nxt.address_match;
            port_ok_ff  <= nxt.port_match;
            queue_ff    <= nxt.frame_queue;
         end
      end
   end

endmodule

>>> rtl/udp_unicast_packet_classifier_unit.sv
// ----------------------------------------------------------------------------
// UDP unicast packet classifier
// Byte-serial IPv4/UDP destination filter with redirect verdict and counters.
//
// Usage:
//   req_* carries an Ethernet frame one byte per item starting at the
//   destination MAC; req_tlast marks the frame's last byte and req_tuser the
//   receive queue (sampled on the first byte).
//   rsp_* gives one item per frame: redirect flag, stop reason and the five
//   wrapping event counters after this frame.
//   csr_* writes the match address, port, enable and socket mask; write only
//   while no frame is in flight.
// Timing:
//   One byte per cycle sustained. A last byte accepted on req_* passes through
//   the input register and, once rsp_* is free, the result register to rsp_*.
//   When rsp_tready is low a finished result holds; bytes that do not end a
//   frame keep flowing, a second frame end waits in the input register.
// Reset:
//   Clears the CSR registers, counters, frame state and both valid flags.
// ----------------------------------------------------------------------------
module udp_unicast_packet_classifier_unit
   import ucpc_pkg::*;
#(
   parameter int NUM_QUEUES = NUM_QUEUES_DEFAULT
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] data_byte
   input  logic                          req_tlast,   // end_of_frame
   input  logic [QUEUE_W-1:0]            req_tuser,   // [5:0] rx_queue
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [63:0] frames_seen, [127:64] ipv4_seen, [191:128] udp_seen,
   // [255:192] target_matched, [319:256] frames_redirected
   output logic [NUM_COUNTERS*CNT_W-1:0] rsp_tdata,
   output logic [4:0]                    rsp_tuser,   // [0] redirect, [4:1] stop_reason
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [CNT_W-1:0]              csr_wdata
);

   logic [31:0]           taddr_ff;
   logic [15:0]           tport_ff;
   logic                  enable_ff;
   logic [NUM_QUEUES-1:0] mask_ff;

   logic                  in_valid_ff;
   logic [7:0]            in_data_ff;
   logic                  in_last_ff;
   logic [QUEUE_W-1:0]    in_queue_ff;

   logic                  out_valid_ff;
   logic [4:0]            out_user_ff;
   logic [CNT_W-1:0]      cnt_ff [NUM_COUNTERS];

   logic                  out_free;
   logic                  byte_fire;
   logic                  frame_done;
   frame_status_type      st;

   logic [7:0]            len;
   logic [7:0]            udp_need;
   logic [NUM_QUEUES-1:0] mask_shift;
   logic                  socket_bound;
   logic [3:0]            reason;
   logic [NUM_COUNTERS-1:0] cnt_inc;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign byte_fire  = in_valid_ff && (!in_last_ff || out_free);
   assign frame_done = byte_fire && in_last_ff;
   assign req_tready = !in_valid_ff || byte_fire;

   ucpc_frame_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .byte_fire       (byte_fire),
      .data_byte       (in_data_ff),
      .end_of_frame    (in_last_ff),
      .rx_queue        (in_queue_ff),
      .target_address  (taddr_ff),
      .target_udp_port (tport_ff),
      .status          (st)
   );

   assign len          = {1'b0, st.pos} + 8'd1;
   assign udp_need     = ETH_HDR_LEN + {2'b00, st.header_words, 2'b00} + UDP_HDR_LEN;
   assign mask_shift   = mask_ff >> st.frame_queue;
   assign socket_bound = ({1'b0, st.frame_queue} < 7'(NUM_QUEUES)) && mask_shift[0];

   always_comb begin
      cnt_inc = '0;
      cnt_inc[CNT_FRAMES] = 1'b1;
      priority if (len < ETH_HDR_LEN) begin
         reason = STOP_SHORT_ETH;
      end else if (!st.ethertype_ok) begin
         reason = STOP_NOT_IPV4;
      end else if (len < ETH_HDR_LEN + IP_MIN_LEN) begin
         cnt_inc[CNT_IPV4] = 1'b1;
         reason = STOP_SHORT_IP;
      end else if (!st.protocol_ok) begin
         cnt_inc[CNT_IPV4] = 1'b1;
         reason = STOP_NOT_UDP;
      end else begin
         cnt_inc[CNT_IPV4] = 1'b1;
         cnt_inc[CNT_UDP]  = 1'b1;
         priority if (st.header_words < IHL_MIN) begin
            reason = STOP_BAD_IHL;
         end else if (len < udp_need) begin
            reason = STOP_SHORT_UDP;
         end else if (!enable_ff) begin
            reason = STOP_DISABLED;
         end else if (!(st.address_match && st.port_match)) begin
            reason = STOP_NO_MATCH;
         end else if (!socket_bound) begin
            cnt_inc[CNT_MATCHED] = 1'b1;
            reason = STOP_NO_SOCKET;
         end else begin
            cnt_inc[CNT_MATCHED]    = 1'b1;
            cnt_inc[CNT_REDIRECTED] = 1'b1;
            reason = STOP_REDIRECTED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taddr_ff  <= '0;
         tport_ff  <= '0;
         enable_ff <= 1'b0;
         mask_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_ADDRESS: taddr_ff  <= csr_wdata[31:0];
            CSR_TARGET_PORT:    tport_ff  <= csr_wdata[15:0];
            CSR_FILTER_ENABLE:  enable_ff <= csr_wdata[0];
            CSR_SOCKET_MASK:    mask_ff   <= csr_wdata[NUM_QUEUES-1:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff  <= req_tdata;
         in_last_ff  <= req_tlast;
         in_queue_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= frame_done;
      end
   end

   always_ff @(posedge clock) begin
      if (frame_done) begin
         out_user_ff <= {reason, (reason == STOP_REDIRECTED)};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
         if (reset) begin
            cnt_ff[i] <= '0;
         end else if (frame_done && cnt_inc[i]) begin
            cnt_ff[i] <= cnt_ff[i] + CNT_W'(1);
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_user_ff;

   always_comb begin
      for (int i = 0; i < NUM_COUNTERS; i++) begin
         rsp_tdata[i*CNT_W +: CNT_W] = cnt_ff[i];
      end
   end

endmodule
